@@ rtl/fcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fcpa_pkg: shared types and constants of the fixed cell pool allocator
// Command and status codes, register indexes, and the control structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package fcpa_pkg;

  // Default sizing of the pool.
  localparam int DEF_MAX_BLOCKS = 8;
  localparam int DEF_CELL_SLOTS = 16;

  // Register reset values.
  localparam logic [4:0] CELLS_RESET  = 5'd16;
  localparam logic [3:0] LIMIT_RESET  = 4'd8;
  localparam logic [7:0] GROWTH_RESET = 8'd16;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CELLS  = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_GROWTH = 2'd2;

  // Item commands.
  localparam logic [1:0] CMD_STATIC  = 2'd0;
  localparam logic [1:0] CMD_DYNAMIC = 2'd1;
  localparam logic [1:0] CMD_FREE    = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_CELL  = 2'd1;
  localparam logic [1:0] ST_AT_LIMIT = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_RD_FRONT,
    DP_RD_NC,
    DP_TAKE,
    DP_EXT_SETUP,
    DP_BUILD,
    DP_FREE_RD,
    DP_FREE_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic at_limit;
    logic free_ok;
    logic cnt_ok;
    logic build_done;
    logic cmd_dynamic;
  } dp_stat_t;

endpackage

@@ rtl/fcpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcpa_ctrl: sequencer of the fixed cell pool allocator
// Steps each item through its read, modify and write cycles and runs the
// block build loop after reset and on pool extension.
// ----------------------------------------------------------------------------
module fcpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_command,
  input  fcpa_pkg::dp_stat_t stat,
  output fcpa_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import fcpa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_A0    = 9'b000000010,
    S_A1    = 9'b000000100,
    S_A2    = 9'b000001000,
    S_D0    = 9'b000010000,
    S_BUILD = 9'b000100000,
    S_F0    = 9'b001000000,
    S_F1    = 9'b010000000,
    S_HOLD  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // State register; reset starts by building block zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BUILD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt      = state_r;
    cmd.op         = DP_NONE;
    cmd.emit       = 1'b0;
    cmd.res_status = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = DP_LOAD;
          unique case (in_command)
            CMD_STATIC:  state_nxt = S_A0;
            CMD_DYNAMIC: state_nxt = S_D0;
            CMD_FREE:    state_nxt = S_F0;
            default:     cmd.emit  = 1'b1;
          endcase
        end
      end
      S_A0: begin
        if (stat.queue_empty) begin
          cmd.emit       = 1'b1;
          cmd.res_status = ST_NO_CELL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op    = DP_RD_FRONT;
          state_nxt = S_A1;
        end
      end
      S_A1: begin
        cmd.op    = DP_RD_NC;
        state_nxt = S_A2;
      end
      S_A2: begin
        cmd.op    = DP_TAKE;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_D0: begin
        if (!stat.queue_empty) begin
          cmd.op    = DP_RD_FRONT;
          state_nxt = S_A1;
        end else if (stat.at_limit) begin
          cmd.emit       = 1'b1;
          cmd.res_status = ST_AT_LIMIT;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op    = DP_EXT_SETUP;
          state_nxt = S_BUILD;
        end
      end
      S_BUILD: begin
        cmd.op = DP_BUILD;
        if (stat.build_done) begin
          state_nxt = stat.cmd_dynamic ? S_HOLD : S_IDLE;
        end
      end
      S_HOLD: begin
        // The last block write settles before the front block is read.
        state_nxt = S_A0;
      end
      S_F0: begin
        if (stat.free_ok) begin
          cmd.op    = DP_FREE_RD;
          state_nxt = S_F1;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_F1: begin
        if (stat.cnt_ok) begin
          cmd.op = DP_FREE_COMMIT;
        end
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/fcpa_dp.sv @@
// ----------------------------------------------------------------------------
// fcpa_dp: datapath of the fixed cell pool allocator
// Holds the configuration, the queue pointers and counters, the per-block
// memories and the cell chain memory, and the result registers.
// ----------------------------------------------------------------------------
module fcpa_dp #(
  parameter int MAX_BLOCKS = fcpa_pkg::DEF_MAX_BLOCKS,
  parameter int CELL_SLOTS = fcpa_pkg::DEF_CELL_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_cell_handle,
  input  fcpa_pkg::dp_cmd_t  cmd,
  output fcpa_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [6:0]         out_granted_cell,
  output logic [1:0]         out_status,
  output logic [7:0]         out_free_cells,
  output logic               out_pool_full,
  output logic [3:0]         out_active_blocks
);
  import fcpa_pkg::*;

  localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW    = $clog2(CELL_SLOTS);
  localparam int POOL  = MAX_BLOCKS * CELL_SLOTS;
  localparam int AW    = $clog2(POOL);
  localparam int ABW   = $clog2(MAX_BLOCKS + 1);
  localparam int CNTW  = $clog2(CELL_SLOTS + 1);
  localparam int FTW   = $clog2(POOL + 1);
  localparam int PW    = ABW + 8;
  localparam int RST_CELLS = (CELL_SLOTS < 16) ? CELL_SLOTS : 16;

  // Configuration registers.
  logic [4:0] cfg_cells_r;
  logic [3:0] cfg_limit_r;
  logic [7:0] cfg_growth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cells_r  <= CELLS_RESET;
      cfg_limit_r  <= LIMIT_RESET;
      cfg_growth_r <= GROWTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_CELLS:  cfg_cells_r  <= cfg_data[4:0];
        REG_LIMIT:  cfg_limit_r  <= cfg_data[3:0];
        REG_GROWTH: cfg_growth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [BW-1:0]   front_r, back_r;
  logic            qempty_r;
  logic [ABW-1:0]  active_r;
  logic [FTW-1:0]  free_total_r;
  logic [1:0]      cmd_r;
  logic [6:0]      handle_r;
  logic [ABW-1:0]  ext_left_r;
  logic [CW-1:0]   bi_r;
  logic [CNTW-1:0] build_cells_r;

  // Memory read data.
  logic [CW-1:0]   hd_rd_r;
  logic [CNTW-1:0] cnt_rd_r;
  logic [BW-1:0]   ql_rd_r;
  logic [CW-1:0]   nc_rd_r;

  // Effective cell count and block limit.
  logic [CNTW-1:0] eff_cells;
  logic [ABW-1:0]  eff_limit;

  always_comb begin
    if (cfg_cells_r == 5'd0) begin
      eff_cells = CNTW'(1);
    end else if (int'(cfg_cells_r) > CELL_SLOTS) begin
      eff_cells = CNTW'(CELL_SLOTS);
    end else begin
      eff_cells = CNTW'(cfg_cells_r);
    end
    if (cfg_limit_r == 4'd0) begin
      eff_limit = ABW'(1);
    end else if (int'(cfg_limit_r) > MAX_BLOCKS) begin
      eff_limit = ABW'(MAX_BLOCKS);
    end else begin
      eff_limit = ABW'(cfg_limit_r);
    end
  end

  // Extension count: max(1, (active * growth) >> 4), capped at the room left.
  logic [PW-1:0] ext_prod;
  logic [PW-1:0] ext_n;
  logic [ABW-1:0] ext_room;
  logic [ABW-1:0] ext_cnt;

  always_comb begin
    ext_prod = PW'(active_r) * PW'(cfg_growth_r);
    ext_n    = ext_prod >> 4;
    ext_room = eff_limit - active_r;
    if (ext_n == '0) begin
      ext_n = PW'(1);
    end
    if (ext_n > PW'(ext_room)) begin
      ext_cnt = ext_room;
    end else begin
      ext_cnt = ABW'(ext_n);
    end
  end

  // Handle decode into block and cell by compares against block bases.
  logic [BW-1:0] fb;
  logic [CW-1:0] fc;
  logic          f_in_range;

  always_comb begin
    fb = '0;
    for (int k = 1; k < MAX_BLOCKS; k++) begin
      if (32'(handle_r) >= k * CELL_SLOTS) begin
        fb = BW'(k);
      end
    end
    f_in_range = 32'(handle_r) < POOL;
    fc = CW'(32'(handle_r) - 32'(fb) * CELL_SLOTS);
  end

  // Addresses into the chain memory.
  logic [BW-1:0] act_blk;
  logic [AW-1:0] front_addr, free_addr, build_addr;
  logic          build_last_cell;

  assign act_blk         = BW'(active_r);
  assign front_addr      = AW'(32'(front_r) * CELL_SLOTS + 32'(hd_rd_r));
  assign free_addr       = AW'(32'(fb) * CELL_SLOTS + 32'(fc));
  assign build_addr      = AW'(32'(act_blk) * CELL_SLOTS + 32'(bi_r));
  assign build_last_cell = (CNTW'(bi_r) + CNTW'(1)) == build_cells_r;

  // Status to the controller.
  assign stat.queue_empty = qempty_r;
  assign stat.at_limit    = active_r >= eff_limit;
  assign stat.free_ok     = f_in_range && (int'(fb) < int'(active_r)) &&
                            (int'(fc) < int'(eff_cells));
  assign stat.cnt_ok      = cnt_rd_r < eff_cells;
  assign stat.build_done  = build_last_cell && (ext_left_r == ABW'(1));
  assign stat.cmd_dynamic = (cmd_r == CMD_DYNAMIC);

  // Memory write ports.
  logic            nc_we, hd_we, cnt_we, ql_we;
  logic [AW-1:0]   nc_wa;
  logic [CW-1:0]   nc_wd;
  logic [BW-1:0]   hd_wa, cnt_wa, ql_wa;
  logic [CW-1:0]   hd_wd;
  logic [CNTW-1:0] cnt_wd;
  logic [BW-1:0]   ql_wd;
  logic [BW-1:0]   blk_ra;

  always_comb begin
    nc_we  = 1'b0;
    hd_we  = 1'b0;
    cnt_we = 1'b0;
    ql_we  = 1'b0;
    nc_wa  = build_addr;
    nc_wd  = build_last_cell ? '0 : CW'(bi_r + CW'(1));
    hd_wa  = act_blk;
    hd_wd  = '0;
    cnt_wa = act_blk;
    cnt_wd = build_cells_r;
    ql_wa  = act_blk;
    ql_wd  = front_r;
    blk_ra = (cmd.op == DP_FREE_RD) ? fb : front_r;
    case (cmd.op)
      DP_BUILD: begin
        nc_we = 1'b1;
        if (build_last_cell) begin
          hd_we  = 1'b1;
          cnt_we = 1'b1;
          ql_we  = !qempty_r;
        end
      end
      DP_TAKE: begin
        hd_we  = 1'b1;
        hd_wa  = front_r;
        hd_wd  = nc_rd_r;
        cnt_we = 1'b1;
        cnt_wa = front_r;
        cnt_wd = cnt_rd_r - CNTW'(1);
      end
      DP_FREE_COMMIT: begin
        nc_we  = 1'b1;
        nc_wa  = free_addr;
        nc_wd  = hd_rd_r;
        hd_we  = 1'b1;
        hd_wa  = fb;
        hd_wd  = fc;
        cnt_we = 1'b1;
        cnt_wa = fb;
        cnt_wd = cnt_rd_r + CNTW'(1);
        ql_we  = !qempty_r && (cnt_rd_r == '0);
        ql_wa  = back_r;
        ql_wd  = fb;
      end
      default: ;
    endcase
  end

  // Cell chain memory.
  logic [CW-1:0] nc_mem [POOL];

  always_ff @(posedge clk) begin
    if (nc_we) begin
      nc_mem[nc_wa] <= nc_wd;
    end
    nc_rd_r <= nc_mem[front_addr];
  end

  // Per-block memories: free list head, free count and queue link.
  logic [CW-1:0]   hd_mem  [MAX_BLOCKS];
  logic [CNTW-1:0] cnt_mem [MAX_BLOCKS];
  logic [BW-1:0]   ql_mem  [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (hd_we) begin
      hd_mem[hd_wa] <= hd_wd;
    end
    hd_rd_r <= hd_mem[blk_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[blk_ra];
  end

  always_ff @(posedge clk) begin
    if (ql_we) begin
      ql_mem[ql_wa] <= ql_wd;
    end
    ql_rd_r <= ql_mem[front_r];
  end

  // Queue pointers, counters and build loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r       <= '0;
      back_r        <= '0;
      qempty_r      <= 1'b1;
      active_r      <= '0;
      free_total_r  <= '0;
      cmd_r         <= CMD_NOP;
      ext_left_r    <= ABW'(1);
      bi_r          <= '0;
      build_cells_r <= CNTW'(RST_CELLS);
    end else begin
      case (cmd.op)
        DP_LOAD: begin
          cmd_r <= in_command;
        end
        DP_EXT_SETUP: begin
          ext_left_r    <= ext_cnt;
          bi_r          <= '0;
          build_cells_r <= eff_cells;
        end
        DP_BUILD: begin
          if (build_last_cell) begin
            bi_r         <= '0;
            free_total_r <= free_total_r + FTW'(build_cells_r);
            if (qempty_r) begin
              back_r   <= act_blk;
              qempty_r <= 1'b0;
            end
            front_r    <= act_blk;
            active_r   <= active_r + ABW'(1);
            ext_left_r <= ext_left_r - ABW'(1);
          end else begin
            bi_r <= bi_r + CW'(1);
          end
        end
        DP_TAKE: begin
          free_total_r <= free_total_r - FTW'(1);
          if (cnt_rd_r == CNTW'(1)) begin
            if (front_r == back_r) begin
              qempty_r <= 1'b1;
            end else begin
              front_r <= ql_rd_r;
            end
          end
        end
        DP_FREE_COMMIT: begin
          free_total_r <= free_total_r + FTW'(1);
          if (cnt_rd_r == '0) begin
            if (qempty_r) begin
              front_r  <= fb;
              qempty_r <= 1'b0;
            end
            back_r <= fb;
          end
        end
        default: ;
      endcase
    end
  end

  // Handle capture on accept.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      handle_r <= in_cell_handle;
    end
  end

  // Result registers.
  logic       out_valid_r;
  logic [6:0] granted_r;
  logic [1:0] status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r  <= cmd.res_status;
      granted_r <= (cmd.op == DP_TAKE) ? 7'(front_addr) : 7'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_cell  = granted_r;
  assign out_status        = status_r;
  assign out_free_cells    = 8'(free_total_r);
  assign out_pool_full     = qempty_r;
  assign out_active_blocks = 4'(active_r);

endmodule

@@ rtl/fixed_cell_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_cell_pool_allocator: cell allocator over a pool of fixed-size blocks
// Each block keeps a LIFO free list; a queue links the blocks with free cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item (command, cell handle) is taken when start is high
//   and busy is low. Commands are static allocate, dynamic allocate with pool
//   extension, and free.
//   Result channel: one result per item, shown for one cycle with out_valid.
//   The receiver cannot stall; free_cells, pool_full and active_blocks give
//   the state after the item.
//   Steps: a free checks the handle, reads the block memories and then
//   commits; an allocate reads the block memories and then the chain memory.
//   An extension runs the build loop, writing one chain entry per cycle for
//   each cell of each new block.
//   Reset: block zero, of min(16, CELL_SLOTS) cells, is built by the same loop
//   with busy high; configuration writes are taken at any time but should be
//   made only while idle.
//   Configuration: cfg_ready is always high; cfg_index selects the register.
// ----------------------------------------------------------------------------
module fixed_cell_pool_allocator #(
  parameter int MAX_BLOCKS = fcpa_pkg::DEF_MAX_BLOCKS,
  parameter int CELL_SLOTS = fcpa_pkg::DEF_CELL_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [6:0] in_cell_handle,
  output logic       out_valid,
  output logic [6:0] out_granted_cell,
  output logic [1:0] out_status,
  output logic [7:0] out_free_cells,
  output logic       out_pool_full,
  output logic [3:0] out_active_blocks
);
  import fcpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  fcpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Datapath with memories and result registers.
  fcpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CELL_SLOTS (CELL_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_cell_handle    (in_cell_handle),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_granted_cell  (out_granted_cell),
    .out_status        (out_status),
    .out_free_cells    (out_free_cells),
    .out_pool_full     (out_pool_full),
    .out_active_blocks (out_active_blocks)
  );

endmodule
